[rtl/mcthq_pkg.sv]
// shared constants and types for the multi-channel touch hold qualifier
package mcthq_pkg;

    // channel count of the block; lanes beyond the twelve mask bits never qualify
    localparam int CHANNELS = 12;
    localparam int MASK_W   = 12;
    localparam int LANES    = (CHANNELS < MASK_W) ? CHANNELS : MASK_W;

    localparam int TIME_W   = 32;
    localparam int HOLD_W   = 16;
    localparam int CFG_IDX_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS     = 2'd1;

    // reset values of the registers
    localparam logic [MASK_W-1:0] ACTIVE_MASK_RST = 12'hFFF;
    localparam logic [HOLD_W-1:0] HOLD_MS_RST     = 16'd500;

    // channel state codes
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FIRST = 2'd1;
    localparam logic [1:0] ST_HELD  = 2'd2;

    // what one lane reports for the word being accepted
    typedef struct packed {
        logic pending;
        logic held;
        logic rise;
        logic fall;
    } lane_res_t;

endpackage

[rtl/multi_channel_touch_hold_qualifier.sv]
// top level of the multi-channel touch hold qualifier
//
// channel   ports                                         direction
// s_        s_valid s_ready s_touched_bits s_now_ms        in
//           s_clear_touches s_clear_releases
// m_        m_valid m_ready m_new_touch_mask               out
//           m_new_release_mask m_pending_mask m_held_mask
// cfg_      cfg_valid cfg_ready cfg_index cfg_data         in
//
// one word per cycle while s_ready is high; each lane updates its state in the accepting cycle
// result word appears in the output register in the cycle after acceptance
// s_ready is low only while a finished word waits and m_ready is low
// synchronous active-low reset: lanes idle, sticky masks and previous touches clear
// cfg_ready is always high; indexes beyond hold_ms are ignored
module multi_channel_touch_hold_qualifier (
    input  logic                                aclk,
    input  logic                                aresetn,
    // sample channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [mcthq_pkg::MASK_W-1:0]        s_touched_bits,
    input  logic [mcthq_pkg::TIME_W-1:0]        s_now_ms,
    input  logic                                s_clear_touches,
    input  logic                                s_clear_releases,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [mcthq_pkg::MASK_W-1:0]        m_new_touch_mask,
    output logic [mcthq_pkg::MASK_W-1:0]        m_new_release_mask,
    output logic [mcthq_pkg::MASK_W-1:0]        m_pending_mask,
    output logic [mcthq_pkg::MASK_W-1:0]        m_held_mask,
    // register write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mcthq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                         cfg_data
);

    // configuration registers
    logic [mcthq_pkg::MASK_W-1:0]   active_mask_reg;
    logic [mcthq_pkg::HOLD_W-1:0]   hold_ms_reg;
    // last accepted touch mask, follows every word for every channel
    logic [mcthq_pkg::MASK_W-1:0]   prev_touched_reg;

    logic                                           accept;
    mcthq_pkg::lane_res_t [mcthq_pkg::LANES-1:0]    lane_res;

    // output register frees as soon as its word is taken
    assign s_ready   = ~m_valid | m_ready;
    assign accept    = s_valid & s_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_mask_reg <= mcthq_pkg::ACTIVE_MASK_RST;
            hold_ms_reg     <= mcthq_pkg::HOLD_MS_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                mcthq_pkg::CFG_ACTIVE_MASK: active_mask_reg <= cfg_data[mcthq_pkg::MASK_W-1:0];
                mcthq_pkg::CFG_HOLD_MS:     hold_ms_reg     <= cfg_data[mcthq_pkg::HOLD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_touched_reg <= '0;
        end else if (accept) begin
            prev_touched_reg <= s_touched_bits;
        end
    end

    // one lane per channel, all working on the same word
    for (genvar g = 0; g < mcthq_pkg::LANES; g++) begin : g_lane
        mcthq_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .accept  (accept),
            .enable  (active_mask_reg[g]),
            .cur     (s_touched_bits[g]),
            .prev    (prev_touched_reg[g]),
            .now_ms  (s_now_ms),
            .hold_ms (hold_ms_reg),
            .res     (lane_res[g])
        );
    end

    // merge lane findings, sticky masks and the result word register
    mcthq_merge u_merge (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .accept           (accept),
        .lane_res         (lane_res),
        .clear_touches    (s_clear_touches),
        .clear_releases   (s_clear_releases),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .new_touch_mask   (m_new_touch_mask),
        .new_release_mask (m_new_release_mask),
        .pending_mask     (m_pending_mask),
        .held_mask        (m_held_mask)
    );

    // a channel is never both pending and held
    a_pend_held_disjoint: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_pending_mask & m_held_mask) == '0))
        else $error("channel reported both pending and held");

    // a released channel cannot be pending or held in the same word (checked on channel 0)
    a_release_is_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !s_touched_bits[0] && prev_touched_reg[0] && active_mask_reg[0]
        |=> !m_pending_mask[0] && !m_held_mask[0] && m_new_release_mask[0])
        else $error("released channel not idle");

    // a fresh touch on an enabled channel always shows as pending (checked on channel 0)
    a_touch_is_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_touched_bits[0] && !prev_touched_reg[0] && active_mask_reg[0]
        |=> m_pending_mask[0] && m_new_touch_mask[0])
        else $error("fresh touch not pending");

    // nothing waits in the output register straight after reset
    a_empty_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word present after reset");

endmodule

[rtl/mcthq_lane.sv]
// one channel of the qualifier: idle, first touch and held states
module mcthq_lane (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            accept,
    input  logic                            enable,
    input  logic                            cur,
    input  logic                            prev,
    input  logic [mcthq_pkg::TIME_W-1:0]    now_ms,
    input  logic [mcthq_pkg::HOLD_W-1:0]    hold_ms,
    output mcthq_pkg::lane_res_t            res
);

    logic [1:0]                      state_reg;
    logic [1:0]                      state_next;
    logic [mcthq_pkg::TIME_W-1:0]    time_reg;
    logic [mcthq_pkg::TIME_W-1:0]    time_next;
    logic [mcthq_pkg::TIME_W-1:0]    elapsed;
    logic                            rise;
    logic                            fall;

    // wrapping difference since first contact
    assign elapsed = now_ms - time_reg;

    always_comb begin
        state_next = state_reg;
        time_next  = time_reg;
        rise       = 1'b0;
        fall       = 1'b0;
        if (enable) begin
            if (state_reg == mcthq_pkg::ST_FIRST && cur &&
                elapsed > {{(mcthq_pkg::TIME_W-mcthq_pkg::HOLD_W){1'b0}}, hold_ms}) begin
                state_next = mcthq_pkg::ST_HELD;
                time_next  = '1;
            end
            // a fresh edge wins over the confirmation
            if (cur && !prev) begin
                state_next = mcthq_pkg::ST_FIRST;
                time_next  = now_ms;
                rise       = 1'b1;
            end
            if (!cur && prev) begin
                state_next = mcthq_pkg::ST_IDLE;
                time_next  = '0;
                fall       = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mcthq_pkg::ST_IDLE;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            time_reg <= time_next;
        end
    end

    assign res.pending = (state_next == mcthq_pkg::ST_FIRST);
    assign res.held    = (state_next == mcthq_pkg::ST_HELD);
    assign res.rise    = rise;
    assign res.fall    = fall;

endmodule

[rtl/mcthq_merge.sv]
// gathers lane results into masks, keeps the sticky masks and the output register
module mcthq_merge (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            accept,
    input  mcthq_pkg::lane_res_t [mcthq_pkg::LANES-1:0]     lane_res,
    input  logic                                            clear_touches,
    input  logic                                            clear_releases,
    input  logic                                            m_ready,
    output logic                                            m_valid,
    output logic [mcthq_pkg::MASK_W-1:0]                    new_touch_mask,
    output logic [mcthq_pkg::MASK_W-1:0]                    new_release_mask,
    output logic [mcthq_pkg::MASK_W-1:0]                    pending_mask,
    output logic [mcthq_pkg::MASK_W-1:0]                    held_mask
);

    logic [mcthq_pkg::MASK_W-1:0] rise_mask;
    logic [mcthq_pkg::MASK_W-1:0] fall_mask;
    logic [mcthq_pkg::MASK_W-1:0] pend_mask;
    logic [mcthq_pkg::MASK_W-1:0] hold_mask;
    logic [mcthq_pkg::MASK_W-1:0] touch_next;
    logic [mcthq_pkg::MASK_W-1:0] release_next;

    logic [mcthq_pkg::MASK_W-1:0] sticky_touch_reg;
    logic [mcthq_pkg::MASK_W-1:0] sticky_release_reg;
    logic                         valid_reg;
    logic                         valid_next;
    logic [mcthq_pkg::MASK_W-1:0] touch_out_reg;
    logic [mcthq_pkg::MASK_W-1:0] release_out_reg;
    logic [mcthq_pkg::MASK_W-1:0] pending_out_reg;
    logic [mcthq_pkg::MASK_W-1:0] held_out_reg;

    always_comb begin
        rise_mask = '0;
        fall_mask = '0;
        pend_mask = '0;
        hold_mask = '0;
        for (int i = 0; i < mcthq_pkg::LANES; i++) begin
            rise_mask[i] = lane_res[i].rise;
            fall_mask[i] = lane_res[i].fall;
            pend_mask[i] = lane_res[i].pending;
            hold_mask[i] = lane_res[i].held;
        end
    end

    assign touch_next   = sticky_touch_reg | rise_mask;
    assign release_next = sticky_release_reg | fall_mask;
    assign valid_next   = accept | (valid_reg & ~m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sticky_touch_reg   <= '0;
            sticky_release_reg <= '0;
            valid_reg          <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (accept) begin
                sticky_touch_reg   <= clear_touches  ? '0 : touch_next;
                sticky_release_reg <= clear_releases ? '0 : release_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            touch_out_reg   <= touch_next;
            release_out_reg <= release_next;
            pending_out_reg <= pend_mask;
            held_out_reg    <= hold_mask;
        end
    end

    assign m_valid          = valid_reg;
    assign new_touch_mask   = touch_out_reg;
    assign new_release_mask = release_out_reg;
    assign pending_mask     = pending_out_reg;
    assign held_mask        = held_out_reg;

endmodule
